/* sv/rtsf_pkg.sv */
// ----------------------------------------------------------------------------
// rtsf_pkg
// Shared widths, codes and types for the resistive touch sampler and filter.
// ----------------------------------------------------------------------------
package rtsf_pkg;

  // Sample ring geometry
  localparam int SAMPLE_COUNT = 6;
  localparam int RAW_W        = 11;
  localparam int ADC_W        = 10;
  localparam int IDX_W        = $clog2(SAMPLE_COUNT);
  localparam logic [RAW_W-1:0] RELEASED_MARK = 11'd1024;

  // Ring average: sum times a rounded-up reciprocal, exact for every sum that fits SUM_W
  localparam int SUM_W     = $clog2(SAMPLE_COUNT * ((1 << RAW_W) - 1) + 1);
  localparam int DIV_SHIFT = SUM_W + $clog2(SAMPLE_COUNT) + 1;
  localparam logic [DIV_SHIFT-1:0] DIV_RECIP =
    DIV_SHIFT'(((1 << DIV_SHIFT) + SAMPLE_COUNT - 1) / SAMPLE_COUNT);

  // Register and coordinate widths
  localparam int GAIN_W       = 20;
  localparam int OFFSET_W     = 24;
  localparam int SIZE_W       = 13;
  localparam int LEVEL_W      = 10;
  localparam int SCREEN_W     = 13;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 24;
  localparam int GAIN_FRAC    = 16;
  localparam int OFFSET_FRAC  = 8;
  localparam logic [SIZE_W-1:0] SCREEN_LIMIT = 13'd4096;

  // Result kinds
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_X,
    CFG_OFFSET_X,
    CFG_GAIN_Y,
    CFG_OFFSET_Y,
    CFG_SCREEN_WIDTH,
    CFG_SCREEN_HEIGHT,
    CFG_TOUCH_THRESHOLD,
    CFG_SPREAD_LIMIT
  } cfg_reg_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0]   gain_x;
    logic signed [OFFSET_W-1:0] offset_x;
    logic signed [GAIN_W-1:0]   gain_y;
    logic signed [OFFSET_W-1:0] offset_y;
    logic [SIZE_W-1:0]          screen_width;
    logic [SIZE_W-1:0]          screen_height;
    logic [LEVEL_W-1:0]         touch_threshold;
    logic [LEVEL_W-1:0]         spread_limit;
  } cfg_t;

  // Sampler stage output, carried to the mapping stage
  typedef struct packed {
    logic             kind;
    logic [3:0]       plate;
    logic [1:0]       discharge;
    logic             channel;
    logic             sample_start;
    logic             convert_start;
    logic             pressed;
    logic [RAW_W-1:0] raw_x;
    logic [RAW_W-1:0] raw_y;
  } stage_t;

endpackage

/* sv/resistive_touch_sampler_filter.sv */
// ----------------------------------------------------------------------------
// resistive_touch_sampler_filter
// Four-wire resistive touch controller: plate sequencer, sample filter and
// calibration map behind valid/ready channels.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while the result is taken; three registers
// (input, sampler, result) each hold one transaction, so the input keeps
// flowing while a result waits, until the sampler and input registers fill.
// Reset (rst, synchronous): phase 0, rings at the released mark, not touched,
// calibration registers at their defaults, pipeline empty.
module resistive_touch_sampler_filter import rtsf_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       func,
  input  logic [ADC_W-1:0]           adc_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       kind,
  output logic [3:0]                 plate_outputs,
  output logic [1:0]                 discharge_pulse,
  output logic                       adc_channel,
  output logic                       sample_start,
  output logic                       convert_start,
  output logic                       pressed,
  output logic [RAW_W-1:0]           raw_x,
  output logic [RAW_W-1:0]           raw_y,
  output logic signed [SCREEN_W-1:0] screen_x,
  output logic signed [SCREEN_W-1:0] screen_y,
  input  logic                       cfg_write,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data
);

  cfg_t                       cfg;
  logic                       in_full;
  logic                       in_func;
  logic [ADC_W-1:0]           in_adc;
  logic                       mid_full;
  stage_t                     mid;
  stage_t                     mid_next;
  stage_t                     res;
  logic signed [SCREEN_W-1:0] res_x, res_y;
  logic signed [SCREEN_W-1:0] map_x, map_y;
  logic signed [SCREEN_W-1:0] screen_x_next, screen_y_next;
  logic                       out_free, mid_free, fire;

  assign out_free = !out_valid || out_ready;
  assign mid_free = !mid_full || out_free;
  assign fire     = in_full && mid_free;
  assign in_ready = !in_full || mid_free;

  rtsf_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rtsf_sampler u_sampler (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .func      (in_func),
    .adc_value (in_adc),
    .cfg       (cfg),
    .result    (mid_next)
  );

  rtsf_axis_map u_map_x (
    .raw    (mid.raw_x),
    .gain   (cfg.gain_x),
    .offset (cfg.offset_x),
    .size   (cfg.screen_width),
    .coord  (map_x)
  );

  rtsf_axis_map u_map_y (
    .raw    (mid.raw_y),
    .gain   (cfg.gain_y),
    .offset (cfg.offset_y),
    .size   (cfg.screen_height),
    .coord  (map_y)
  );

  always_comb begin
    if (mid.kind != KIND_READ) begin
      screen_x_next = '0;
      screen_y_next = '0;
    end else if (mid.raw_x == RELEASED_MARK || mid.raw_y == RELEASED_MARK) begin
      screen_x_next = {SCREEN_W{1'b1}};
      screen_y_next = {SCREEN_W{1'b1}};
    end else begin
      screen_x_next = map_x;
      screen_y_next = map_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      mid_full  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        in_full <= 1'b1;
      end else if (fire) begin
        in_full <= 1'b0;
      end
      if (fire) begin
        mid_full <= 1'b1;
      end else if (mid_full && out_free) begin
        mid_full <= 1'b0;
      end
      if (mid_full && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_func <= func;
      in_adc  <= adc_value;
    end
    if (fire) begin
      mid <= mid_next;
    end
    if (mid_full && out_free) begin
      res   <= mid;
      res_x <= screen_x_next;
      res_y <= screen_y_next;
    end
  end

  assign kind            = res.kind;
  assign plate_outputs   = res.plate;
  assign discharge_pulse = res.discharge;
  assign adc_channel     = res.channel;
  assign sample_start    = res.sample_start;
  assign convert_start   = res.convert_start;
  assign pressed         = res.pressed;
  assign raw_x           = res.raw_x;
  assign raw_y           = res.raw_y;
  assign screen_x        = res_x;
  assign screen_y        = res_y;

endmodule

/* sv/rtsf_cfg_regs.sv */
// ----------------------------------------------------------------------------
// rtsf_cfg_regs
// Calibration and threshold register file, written through a plain write port.
// ----------------------------------------------------------------------------
module rtsf_cfg_regs import rtsf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_x           <= 20'sd25539;
      cfg.offset_x         <= -24'sd8069;
      cfg.gain_y           <= -20'sd20801;
      cfg.offset_y         <= 24'sd71117;
      cfg.screen_width     <= 13'd320;
      cfg.screen_height    <= 13'd240;
      cfg.touch_threshold  <= 10'd100;
      cfg.spread_limit     <= 10'd12;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        CFG_GAIN_X:           cfg.gain_x           <= $signed(cfg_data[GAIN_W-1:0]);
        CFG_OFFSET_X:         cfg.offset_x         <= $signed(cfg_data[OFFSET_W-1:0]);
        CFG_GAIN_Y:           cfg.gain_y           <= $signed(cfg_data[GAIN_W-1:0]);
        CFG_OFFSET_Y:         cfg.offset_y         <= $signed(cfg_data[OFFSET_W-1:0]);
        CFG_SCREEN_WIDTH:     cfg.screen_width     <= cfg_data[SIZE_W-1:0];
        CFG_SCREEN_HEIGHT:    cfg.screen_height    <= cfg_data[SIZE_W-1:0];
        CFG_TOUCH_THRESHOLD:  cfg.touch_threshold  <= cfg_data[LEVEL_W-1:0];
        CFG_SPREAD_LIMIT:     cfg.spread_limit     <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* sv/rtsf_sampler.sv */
// ----------------------------------------------------------------------------
// rtsf_sampler
// Nine-phase plate sequencer, sample rings and ring filter. All state moves
// on the cycle an item leaves the input register.
// ----------------------------------------------------------------------------
module rtsf_sampler import rtsf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  logic             func,
  input  logic [ADC_W-1:0] adc_value,
  input  cfg_t             cfg,
  output stage_t           result
);

  localparam logic [3:0] PLATE_DETECT = 4'h1;
  localparam logic [3:0] PLATE_Y_READ = 4'h3;
  localparam logic [3:0] PLATE_X_READ = 4'hC;
  localparam logic [1:0] DIS_NONE     = 2'd0;
  localparam logic [1:0] DIS_Y        = 2'd1;
  localparam logic [1:0] DIS_X        = 2'd2;
  localparam logic       CH_Y_PLATE   = 1'b0;
  localparam logic       CH_X_PLATE   = 1'b1;

  typedef enum logic [3:0] {
    PH_DET_SELECT,
    PH_DET_SAMPLE,
    PH_DET_CONVERT,
    PH_Y_DISCHARGE,
    PH_Y_SAMPLE,
    PH_Y_CONVERT,
    PH_X_DISCHARGE,
    PH_X_SAMPLE,
    PH_X_CONVERT
  } phase_t;

  phase_t                      phase, phase_next;
  logic [RAW_W-1:0]            x_ring [SAMPLE_COUNT];
  logic [RAW_W-1:0]            y_ring [SAMPLE_COUNT];
  logic [IDX_W-1:0]            write_index, write_index_next;
  logic                        touched, touched_next;
  logic [RAW_W-1:0]            held_x, held_x_next;
  logic [RAW_W-1:0]            held_y, held_y_next;
  logic [IDX_W-1:0]            slot, slot_inc;
  logic                        flush, store_x, store_y;
  logic [SUM_W-1:0]            sum_x, sum_y;
  logic [SUM_W+DIV_SHIFT-1:0]  prod_x, prod_y;
  logic [RAW_W-1:0]            avg_x, avg_y;
  logic                        bounce;

  function automatic logic too_far(input logic [RAW_W-1:0]   avg,
                                   input logic [RAW_W-1:0]   smp,
                                   input logic [LEVEL_W-1:0] tol);
    logic [RAW_W-1:0] gap;
    gap = (avg > smp) ? avg - smp : smp - avg;
    return gap > RAW_W'(tol);
  endfunction

  assign slot     = (32'(write_index) < SAMPLE_COUNT) ? write_index : '0;
  assign slot_inc = (slot == IDX_W'(SAMPLE_COUNT - 1)) ? '0 : slot + 1'b1;

  // Ring averages and bounce check
  always_comb begin
    sum_x  = '0;
    sum_y  = '0;
    bounce = 1'b0;
    for (int i = 0; i < SAMPLE_COUNT; i++) begin
      sum_x = sum_x + SUM_W'(x_ring[i]);
      sum_y = sum_y + SUM_W'(y_ring[i]);
    end
    prod_x = sum_x * DIV_RECIP;
    prod_y = sum_y * DIV_RECIP;
    avg_x  = prod_x[DIV_SHIFT +: RAW_W];
    avg_y  = prod_y[DIV_SHIFT +: RAW_W];
    for (int i = 0; i < SAMPLE_COUNT; i++) begin
      if (too_far(avg_x, x_ring[i], cfg.spread_limit) ||
          too_far(avg_y, y_ring[i], cfg.spread_limit)) begin
        bounce = 1'b1;
      end
    end
  end

  always_comb begin
    phase_next       = phase;
    write_index_next = write_index;
    touched_next     = touched;
    held_x_next      = held_x;
    held_y_next      = held_y;
    flush            = 1'b0;
    store_x          = 1'b0;
    store_y          = 1'b0;
    result           = '0;
    result.kind      = func;
    result.discharge = DIS_NONE;
    result.channel   = CH_Y_PLATE;
    if (func == KIND_TICK) begin
      case (phase)
        PH_DET_SELECT: begin
          result.plate = PLATE_DETECT;
          phase_next   = PH_DET_SAMPLE;
        end
        PH_DET_SAMPLE: begin
          result.plate        = PLATE_DETECT;
          result.sample_start = 1'b1;
          phase_next          = PH_DET_CONVERT;
        end
        PH_DET_CONVERT: begin
          result.plate         = PLATE_DETECT;
          result.convert_start = 1'b1;
          if (adc_value > cfg.touch_threshold) begin
            // release: flush only on the touched-to-released edge
            if (touched) begin
              flush            = 1'b1;
              write_index_next = '0;
            end
            touched_next = 1'b0;
            phase_next   = PH_DET_SELECT;
          end else begin
            touched_next     = 1'b1;
            write_index_next = slot_inc;
            phase_next       = PH_Y_DISCHARGE;
          end
        end
        PH_Y_DISCHARGE: begin
          result.plate     = PLATE_Y_READ;
          result.discharge = DIS_Y;
          phase_next       = PH_Y_SAMPLE;
        end
        PH_Y_SAMPLE: begin
          result.plate        = PLATE_Y_READ;
          result.sample_start = 1'b1;
          phase_next          = PH_Y_CONVERT;
        end
        PH_Y_CONVERT: begin
          result.plate         = PLATE_Y_READ;
          result.convert_start = 1'b1;
          store_y              = 1'b1;
          phase_next           = PH_X_DISCHARGE;
        end
        PH_X_DISCHARGE: begin
          result.plate     = PLATE_X_READ;
          result.discharge = DIS_X;
          result.channel   = CH_X_PLATE;
          phase_next       = PH_X_SAMPLE;
        end
        PH_X_SAMPLE: begin
          result.plate        = PLATE_X_READ;
          result.channel      = CH_X_PLATE;
          result.sample_start = 1'b1;
          phase_next          = PH_X_CONVERT;
        end
        PH_X_CONVERT: begin
          result.plate         = PLATE_X_READ;
          result.channel       = CH_X_PLATE;
          result.convert_start = 1'b1;
          store_x              = 1'b1;
          phase_next           = PH_DET_SELECT;
        end
        default: phase_next = PH_DET_SELECT;
      endcase
    end else begin
      if (!touched) begin
        held_x_next = RELEASED_MARK;
        held_y_next = RELEASED_MARK;
      end else if (!bounce) begin
        held_x_next = avg_x;
        held_y_next = avg_y;
      end
      result.raw_x = held_x_next;
      result.raw_y = held_y_next;
    end
    result.pressed = touched_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_DET_SELECT;
      write_index <= '0;
      touched     <= 1'b0;
      held_x      <= RELEASED_MARK;
      held_y      <= RELEASED_MARK;
      for (int i = 0; i < SAMPLE_COUNT; i++) begin
        x_ring[i] <= RELEASED_MARK;
        y_ring[i] <= RELEASED_MARK;
      end
    end else if (fire) begin
      phase       <= phase_next;
      write_index <= write_index_next;
      touched     <= touched_next;
      held_x      <= held_x_next;
      held_y      <= held_y_next;
      for (int i = 0; i < SAMPLE_COUNT; i++) begin
        if (flush) begin
          x_ring[i] <= RELEASED_MARK;
          y_ring[i] <= RELEASED_MARK;
        end else begin
          if (store_x && slot == IDX_W'(i)) begin
            x_ring[i] <= RAW_W'(adc_value);
          end
          if (store_y && slot == IDX_W'(i)) begin
            y_ring[i] <= RAW_W'(adc_value);
          end
        end
      end
    end
  end

endmodule

/* sv/rtsf_axis_map.sv */
// ----------------------------------------------------------------------------
// rtsf_axis_map
// One axis of the calibration map: gain * raw + offset, truncated and
// clamped to the screen size.
// ----------------------------------------------------------------------------
module rtsf_axis_map import rtsf_pkg::*; (
  input  logic [RAW_W-1:0]           raw,
  input  logic signed [GAIN_W-1:0]   gain,
  input  logic signed [OFFSET_W-1:0] offset,
  input  logic [SIZE_W-1:0]          size,
  output logic signed [SCREEN_W-1:0] coord
);

  localparam int PROD_W  = GAIN_W + RAW_W + 1;
  localparam int OFS_W   = OFFSET_W + GAIN_FRAC - OFFSET_FRAC;
  localparam int ACC_W   = ((PROD_W > OFS_W) ? PROD_W : OFS_W) + 1;
  localparam int WHOLE_W = ACC_W - 1 - GAIN_FRAC;

  logic signed [PROD_W-1:0] product;
  logic signed [ACC_W-1:0]  acc;
  logic [WHOLE_W-1:0]       whole;
  logic [SIZE_W-1:0]        limit;

  assign product = gain * $signed({1'b0, raw});
  assign acc     = {{(ACC_W - PROD_W){product[PROD_W-1]}}, product}
                 + {{(ACC_W - OFS_W){offset[OFFSET_W-1]}}, offset,
                    {(GAIN_FRAC - OFFSET_FRAC){1'b0}}};
  // only read when acc is non-negative, so the shift equals truncation
  assign whole   = acc[ACC_W-2:GAIN_FRAC];
  assign limit   = (size > SCREEN_LIMIT) ? SCREEN_LIMIT : size;

  always_comb begin
    if (acc[ACC_W-1] || limit == '0) begin
      coord = '0;
    end else if (whole >= WHOLE_W'(limit)) begin
      coord = $signed(limit - 1'b1);
    end else begin
      coord = $signed(whole[SCREEN_W-1:0]);
    end
  end

endmodule

/* sv/rtsf_checker.sv */
// ----------------------------------------------------------------------------
// rtsf_checker
// Port-level checks on result transactions of the touch sampler and filter.
// ----------------------------------------------------------------------------
module rtsf_checker import rtsf_pkg::*; (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       kind,
  input logic [3:0]                 plate_outputs,
  input logic [1:0]                 discharge_pulse,
  input logic                       adc_channel,
  input logic                       sample_start,
  input logic                       convert_start,
  input logic                       pressed,
  input logic [RAW_W-1:0]           raw_x,
  input logic [RAW_W-1:0]           raw_y,
  input logic signed [SCREEN_W-1:0] screen_x,
  input logic signed [SCREEN_W-1:0] screen_y
);

  // tick results carry no coordinates
  a_tick_no_point: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_TICK |->
      raw_x == '0 && raw_y == '0 && screen_x == '0 && screen_y == '0)
    else $error("tick transaction carries a point");

  // read results carry no plate drive or strobes
  a_read_no_drive: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_READ |->
      plate_outputs == '0 && discharge_pulse == '0 && !adc_channel &&
      !sample_start && !convert_start)
    else $error("read transaction carries plate drive");

  // a read while released reports the released marker
  a_released_raw: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_READ && !pressed |->
      raw_x == RELEASED_MARK && raw_y == RELEASED_MARK)
    else $error("released read without released marker");

  // released raw point maps to -1 on both axes
  a_released_screen: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_READ &&
    (raw_x == RELEASED_MARK || raw_y == RELEASED_MARK) |->
      screen_x == {SCREEN_W{1'b1}} && screen_y == {SCREEN_W{1'b1}})
    else $error("released point not mapped to -1");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable(kind) && $stable(raw_x) && $stable(screen_x) &&
      $stable(screen_y) && $stable(plate_outputs))
    else $error("stalled result transaction changed");

endmodule

bind resistive_touch_sampler_filter rtsf_checker u_rtsf_checker (.*);
